// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== hw/rtl/pf_pkg.sv =====
package pf_pkg;

   localparam int LetterW = 5;
   localparam int CoordW  = 3;
   localparam int Letters = 26;
   localparam int Cells   = 25;
   localparam int Side    = 5;

   localparam logic [LetterW-1:0] LetterI    = 5'd8;
   localparam logic [LetterW-1:0] LetterJ    = 5'd9;
   localparam logic [LetterW-1:0] LetterX    = 5'd23;
   localparam logic [LetterW-1:0] LetterLast = 5'(Letters - 1);
   localparam logic [CoordW-1:0]  CoordLast  = 3'(Side - 1);

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_KEY     = 3'd1,
      OP_FINISH  = 3'd2,
      OP_ENCRYPT = 3'd3,
      OP_DECRYPT = 3'd4
   } op_type;

   typedef struct packed {
      logic [CoordW-1:0] row;
      logic [CoordW-1:0] col;
   } pos_type;

   // one placement into the square and the position table
   typedef struct packed {
      logic               en;
      logic [LetterW-1:0] slot;
      logic [LetterW-1:0] letter;
      pos_type            pos;
   } place_type;

   // saturate to z and fold j onto i
   function automatic logic [LetterW-1:0] pair_letter(input logic [LetterW-1:0] v);
      logic [LetterW-1:0] c;
      c = (v > LetterLast) ? LetterLast : v;
      if (c == LetterJ) begin
         c = LetterI;
      end
      return c;
   endfunction

   // one step around a row or column, forward or back
   function automatic logic [CoordW-1:0] coord_step(input logic [CoordW-1:0] c,
                                                    input logic back);
      logic [CoordW-1:0] r;
      if (back) begin
         r = (c == '0) ? CoordLast : c - 3'd1;
      end else begin
         r = (c == CoordLast) ? '0 : c + 3'd1;
      end
      return r;
   endfunction

   // row * 5 + col
   function automatic logic [LetterW-1:0] cell_index(input pos_type p);
      return {p.row, 2'b00} + {2'b00, p.row} + {2'b00, p.col};
   endfunction

endpackage

// ===== hw/rtl/pf_ram2r.sv =====
module pf_ram2r #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_a,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_a_ff;
   logic [Width-1:0] rd_b_ff;

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/pf_keyctl.sv =====
`include "assert_macros.svh"

module pf_keyctl import pf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               key_en,
   input  logic [LetterW-1:0] key_letter,
   input  logic               finish_start,
   output logic               busy,
   output place_type          place,
   output logic [Letters-1:0] seen,
   output logic [LetterW-1:0] fill
);

   logic [Letters-1:0] seen_ff, seen_in;
   logic [LetterW-1:0] fill_ff, fill_in;
   pos_type            next_ff, next_in;
   logic               walking_ff, walking_in;
   logic [LetterW-1:0] walk_ff, walk_in;

   logic [LetterW-1:0] cand;
   logic               want;
   logic               fresh;

   always_comb begin
      cand  = walking_ff ? walk_ff : ((key_letter == LetterJ) ? LetterI : key_letter);
      want  = walking_ff ? (walk_ff != LetterJ) : key_en;
      fresh = (cand <= LetterLast) ? !seen_ff[cand] : 1'b0;

      place.en     = want && fresh && (fill_ff != 5'(Cells));
      place.slot   = fill_ff;
      place.letter = cand;
      place.pos    = next_ff;
   end

   always_comb begin
      seen_in    = seen_ff;
      fill_in    = fill_ff;
      next_in    = next_ff;
      walking_in = walking_ff;
      walk_in    = walk_ff;
      if (clear) begin
         seen_in    = '0;
         fill_in    = '0;
         next_in    = '0;
         walking_in = 1'b0;
         walk_in    = '0;
      end else begin
         if (place.en) begin
            seen_in[cand] = 1'b1;
            fill_in       = fill_ff + 5'd1;
            if (next_ff.col == CoordLast) begin
               next_in.col = '0;
               next_in.row = next_ff.row + 3'd1;
            end else begin
               next_in.col = next_ff.col + 3'd1;
            end
         end
         if (finish_start) begin
            walking_in = 1'b1;
            walk_in    = '0;
         end else if (walking_ff) begin
            walking_in = (walk_ff != LetterLast);
            walk_in    = walk_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         fill_ff    <= '0;
         next_ff    <= '0;
         walking_ff <= 1'b0;
         walk_ff    <= '0;
      end else begin
         seen_ff    <= seen_in;
         fill_ff    <= fill_in;
         next_ff    <= next_in;
         walking_ff <= walking_in;
         walk_ff    <= walk_in;
      end
   end

   assign busy = walking_ff;
   assign seen = seen_ff;
   assign fill = fill_ff;

   `ASSERT_IMPLIES(a_seen_matches_fill, clock, reset, 1'b1, $countones(seen_ff) == fill_ff, "seen count and fill count disagree")
   `ASSERT_NEVER(a_fill_limit, clock, reset, fill_ff > 5'(Cells), "fill count beyond square size")
   `ASSERT_NEXT(a_walk_ends, clock, reset, walking_ff && (walk_ff == LetterLast), !walking_ff, "finish walk did not end after the last letter")

endmodule

// ===== hw/rtl/pf_cipher.sv =====
module pf_cipher import pf_pkg::*; (
   input  logic               clock,
   input  logic               start,
   input  logic               decrypt,
   input  logic [LetterW-1:0] first_letter,
   input  logic [LetterW-1:0] second_letter,
   input  logic               second_present,
   input  logic [Letters-1:0] seen,
   input  logic [LetterW-1:0] fill,
   output logic [LetterW-1:0] pos_addr_a,
   output logic [LetterW-1:0] pos_addr_b,
   input  pos_type            pos_a,
   input  pos_type            pos_b,
   input  logic               advance,
   output logic [LetterW-1:0] cell_addr_a,
   output logic [LetterW-1:0] cell_addr_b,
   input  logic [LetterW-1:0] sq_a,
   input  logic [LetterW-1:0] sq_b,
   output logic [LetterW-1:0] res_first,
   output logic [LetterW-1:0] res_second
);

   logic               seen_a_ff, seen_a_in;
   logic               seen_b_ff, seen_b_in;
   logic               back_ff, back_in;
   logic               ok_a_ff, ok_a_in;
   logic               ok_b_ff, ok_b_in;

   logic [LetterW-1:0] a, b;
   pos_type            pa, pb, qa, qb;

   // letter normalization and position lookup addresses
   always_comb begin
      a = pair_letter(first_letter);
      b = second_present ? pair_letter(second_letter) : LetterX;
      if (!decrypt && (a == b)) begin
         b = LetterX;
      end
      pos_addr_a = a;
      pos_addr_b = b;
      seen_a_in  = start ? seen[a] : seen_a_ff;
      seen_b_in  = start ? seen[b] : seen_b_ff;
      back_in    = start ? decrypt : back_ff;
   end

   // playfair rules on the looked-up positions
   always_comb begin
      pa = seen_a_ff ? pos_a : '0;
      pb = seen_b_ff ? pos_b : '0;
      if (pa.row == pb.row) begin
         qa = '{row: pa.row, col: coord_step(pa.col, back_ff)};
         qb = '{row: pb.row, col: coord_step(pb.col, back_ff)};
      end else if (pa.col == pb.col) begin
         qa = '{row: coord_step(pa.row, back_ff), col: pa.col};
         qb = '{row: coord_step(pb.row, back_ff), col: pb.col};
      end else begin
         qa = '{row: pa.row, col: pb.col};
         qb = '{row: pb.row, col: pa.col};
      end
      cell_addr_a = cell_index(qa);
      cell_addr_b = cell_index(qb);
      ok_a_in     = advance ? (cell_addr_a < fill) : ok_a_ff;
      ok_b_in     = advance ? (cell_addr_b < fill) : ok_b_ff;
   end

   always_ff @(posedge clock) begin
      seen_a_ff <= seen_a_in;
      seen_b_ff <= seen_b_in;
      back_ff   <= back_in;
      ok_a_ff   <= ok_a_in;
      ok_b_ff   <= ok_b_in;
   end

   // cells not yet filled read as letter a
   assign res_first  = ok_a_ff ? sq_a : '0;
   assign res_second = ok_b_ff ? sq_b : '0;

endmodule

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// playfair cipher over a 5x5 key square, i and j sharing one cell. a clear word
// empties the square, key letter words place new letters row by row, and a finish
// word fills the remaining cells alphabetically; encrypt and decrypt words then
// turn one letter pair into one result word. an encrypt or decrypt pair goes
// through two chained registered memory reads, the letter position table and
// then the key square, and then into the result register. a finish word walks
// each letter of the alphabet through the placement logic. the result
// register lets the next word in while a result still waits downstream; a new
// pair only stalls at its last step if the previous result has not been taken.
// after reset the block is ready at once: the tables need no clearing pass, since
// seen flags and the fill count mask entries that were never written.

`include "assert_macros.svh"

module playfair_digraph_cipher import pf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [LetterW-1:0] req_first_letter,
   input  logic [LetterW-1:0] req_second_letter,
   input  logic               req_second_present,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [LetterW-1:0] rsp_out_first,
   output logic [LetterW-1:0] rsp_out_second
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POS,
      ST_CELL
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LetterW-1:0] rsp_first_ff, rsp_first_in;
   logic [LetterW-1:0] rsp_second_ff, rsp_second_in;

   logic               accept;
   logic               is_cipher;
   logic               pos_re;
   logic               sq_re;
   logic               load;

   logic               key_busy;
   place_type          place;
   logic [Letters-1:0] seen;
   logic [LetterW-1:0] fill;

   logic [LetterW-1:0] pos_addr_a, pos_addr_b;
   pos_type            pos_a, pos_b;
   logic [LetterW-1:0] cell_addr_a, cell_addr_b;
   logic [LetterW-1:0] sq_a, sq_b;
   logic [LetterW-1:0] res_first, res_second;

   // input side only opens in idle and outside the finish walk
   assign req_stall = (state_ff != ST_IDLE) || key_busy;
   assign accept    = req_valid && !req_stall;
   assign is_cipher = (req_operation == OP_ENCRYPT) || (req_operation == OP_DECRYPT);

   // reads never meet a placement: placements happen only on idle accepts
   // of key words or during the walk, both of which keep the pair path quiet
   assign pos_re = accept && is_cipher;
   assign sq_re  = (state_ff == ST_POS);
   assign load   = (state_ff == ST_CELL) && (!rsp_valid_ff || !rsp_stall);

   pf_keyctl u_keyctl (
      .clock        (clock),
      .reset        (reset),
      .clear        (accept && (req_operation == OP_CLEAR)),
      .key_en       (accept && (req_operation == OP_KEY)),
      .key_letter   (req_first_letter),
      .finish_start (accept && (req_operation == OP_FINISH)),
      .busy         (key_busy),
      .place        (place),
      .seen         (seen),
      .fill         (fill)
   );

   // letter -> {row, col}
   pf_ram2r #(
      .Width ($bits(pos_type)),
      .Depth (Letters)
   ) u_pos_ram (
      .clock     (clock),
      .wr_en     (place.en),
      .wr_addr   (place.letter),
      .wr_data   (place.pos),
      .rd_en     (pos_re),
      .rd_addr_a (pos_addr_a),
      .rd_addr_b (pos_addr_b),
      .rd_data_a (pos_a),
      .rd_data_b (pos_b)
   );

   // cell -> letter, row major
   pf_ram2r #(
      .Width (LetterW),
      .Depth (Cells)
   ) u_square_ram (
      .clock     (clock),
      .wr_en     (place.en),
      .wr_addr   (place.slot),
      .wr_data   (place.letter),
      .rd_en     (sq_re),
      .rd_addr_a (cell_addr_a),
      .rd_addr_b (cell_addr_b),
      .rd_data_a (sq_a),
      .rd_data_b (sq_b)
   );

   pf_cipher u_cipher (
      .clock          (clock),
      .start          (pos_re),
      .decrypt        (req_operation == OP_DECRYPT),
      .first_letter   (req_first_letter),
      .second_letter  (req_second_letter),
      .second_present (req_second_present),
      .seen           (seen),
      .fill           (fill),
      .pos_addr_a     (pos_addr_a),
      .pos_addr_b     (pos_addr_b),
      .pos_a          (pos_a),
      .pos_b          (pos_b),
      .advance        (sq_re),
      .cell_addr_a    (cell_addr_a),
      .cell_addr_b    (cell_addr_b),
      .sq_a           (sq_a),
      .sq_b           (sq_b),
      .res_first      (res_first),
      .res_second     (res_second)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pos_re) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            state_in = ST_CELL;
         end
         ST_CELL: begin
            // hold the square data until the result register frees up
            if (load) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_first_in  = res_first;
               rsp_second_in = res_second;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;

   `ASSERT_NEVER(a_no_read_during_place, clock, reset, (pos_re || sq_re) && place.en, "table read overlaps a placement")
   `ASSERT_IMPLIES(a_result_from_cell, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_CELL, "result word raised outside the square read step")
   `ASSERT_IMPLIES(a_walk_blocks_pairs, clock, reset, key_busy, state_ff == ST_IDLE, "pair in flight during the finish walk")

endmodule
